// ===== hw/rtl/esc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the compensation program for the sensor
// compensation block. Used by the controller, datapath and top level.
package esc_pkg;

	localparam int unsigned DW       = 64;
	localparam int unsigned REGS     = 16;
	localparam int unsigned RAW      = 4;
	localparam int unsigned PC_W     = 7;
	localparam int unsigned SH_W     = 6;
	localparam int unsigned CFG_IW   = 3;
	localparam int unsigned IN_W     = 56;
	localparam int unsigned OUT_W    = 104;

	localparam logic [63:0] HUM_MAX  = 64'd419430400;
	localparam logic [16:0] HUM_SAT  = 17'd102400;

	// register indexes of the configuration port
	localparam logic [CFG_IW-1:0] CFG_ENABLE = 3'd0;
	localparam logic [CFG_IW-1:0] CFG_TEMP   = 3'd1;
	localparam logic [CFG_IW-1:0] CFG_PRES_A = 3'd2;
	localparam logic [CFG_IW-1:0] CFG_PRES_B = 3'd3;
	localparam logic [CFG_IW-1:0] CFG_PRES_C = 3'd4;
	localparam logic [CFG_IW-1:0] CFG_HUM    = 3'd5;
	localparam logic [CFG_IW-1:0] CFG_OFFSET = 3'd6;

	typedef enum logic [3:0] {
		OP_LD, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_DIVP, OP_SHL,
		OP_FINE, OP_OUTT, OP_OUTP, OP_OUTH, OP_END
	} op_t;

	typedef enum logic [4:0] {
		S_ADC_T, S_ADC_P, S_ADC_H,
		S_T1, S_T2, S_T3,
		S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_P9,
		S_H1, S_H2, S_H3, S_H4, S_H5, S_H6,
		S_OFFSET, S_K128, S_K128000, S_K2P47, S_K1M, S_K3125,
		S_K76800, S_K16384, S_K32768, S_K2097152, S_K8192
	} src_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_FETCH, ST_EXEC, ST_WAIT, ST_PUBLISH
	} state_t;

	typedef struct packed {
		op_t              op;
		logic [RAW-1:0]   dst;
		logic [RAW-1:0]   ra;
		logic [RAW-1:0]   rb;
		logic [SH_W-1:0]  sh;
		src_t             src;
	} instr_t;

	typedef struct packed {
		logic [2:0]  en;
		logic [47:0] tc;
		logic [47:0] pa;
		logic [47:0] pb;
		logic [47:0] pc;
		logic [63:0] hc;
		logic [20:0] off;
	} cfg_t;

	typedef struct packed {
		logic   capture;
		logic   exec;
		logic   publish;
		instr_t ins;
	} dp_cmd_t;

	typedef struct packed {
		logic unit_done;
	} dp_stat_t;

	function automatic instr_t mk_i(op_t op, int d, int a, int b, int k, src_t s);
		instr_t r;
		r.op  = op;
		r.dst = RAW'(d);
		r.ra  = RAW'(a);
		r.rb  = RAW'(b);
		r.sh  = SH_W'(k);
		r.src = s;
		return r;
	endfunction

	function automatic instr_t ld_i(int d, src_t s);
		return mk_i(OP_LD, d, 0, 0, 0, s);
	endfunction

	function automatic instr_t rr_i(op_t op, int d, int a, int b);
		return mk_i(op, d, a, b, 0, S_ADC_T);
	endfunction

	function automatic instr_t sh_i(op_t op, int d, int a, int k);
		return mk_i(op, d, a, 0, k, S_ADC_T);
	endfunction

	// Compensation program. r15 holds the fine temperature once set.
	function automatic instr_t prog(input logic [PC_W-1:0] pc);
		instr_t r;
		case (pc)
			// temperature
			7'd0:   r = ld_i(0, S_ADC_T);
			7'd1:   r = ld_i(1, S_T1);
			7'd2:   r = ld_i(2, S_T2);
			7'd3:   r = ld_i(3, S_T3);
			7'd4:   r = sh_i(OP_DIVP, 4, 0, 3);
			7'd5:   r = rr_i(OP_ADD, 5, 1, 1);
			7'd6:   r = rr_i(OP_SUB, 4, 4, 5);
			7'd7:   r = rr_i(OP_MUL, 4, 4, 2);
			7'd8:   r = sh_i(OP_DIVP, 4, 4, 11);
			7'd9:   r = sh_i(OP_DIVP, 5, 0, 4);
			7'd10:  r = rr_i(OP_SUB, 5, 5, 1);
			7'd11:  r = rr_i(OP_MUL, 5, 5, 5);
			7'd12:  r = sh_i(OP_DIVP, 5, 5, 12);
			7'd13:  r = rr_i(OP_MUL, 5, 5, 3);
			7'd14:  r = sh_i(OP_DIVP, 5, 5, 14);
			7'd15:  r = rr_i(OP_ADD, 4, 4, 5);
			7'd16:  r = ld_i(5, S_OFFSET);
			7'd17:  r = rr_i(OP_ADD, 4, 4, 5);
			7'd18:  r = rr_i(OP_FINE, 15, 4, 0);
			7'd19:  r = sh_i(OP_SHL, 4, 15, 2);
			7'd20:  r = rr_i(OP_ADD, 4, 4, 15);
			7'd21:  r = ld_i(5, S_K128);
			7'd22:  r = rr_i(OP_ADD, 4, 4, 5);
			7'd23:  r = sh_i(OP_DIVP, 4, 4, 8);
			7'd24:  r = rr_i(OP_OUTT, 0, 4, 0);
			// pressure
			7'd25:  r = ld_i(0, S_K128000);
			7'd26:  r = rr_i(OP_SUB, 1, 15, 0);
			7'd27:  r = rr_i(OP_MUL, 2, 1, 1);
			7'd28:  r = ld_i(3, S_P6);
			7'd29:  r = rr_i(OP_MUL, 4, 2, 3);
			7'd30:  r = ld_i(3, S_P5);
			7'd31:  r = rr_i(OP_MUL, 5, 1, 3);
			7'd32:  r = sh_i(OP_SHL, 5, 5, 17);
			7'd33:  r = rr_i(OP_ADD, 4, 4, 5);
			7'd34:  r = ld_i(3, S_P4);
			7'd35:  r = sh_i(OP_SHL, 3, 3, 35);
			7'd36:  r = rr_i(OP_ADD, 4, 4, 3);
			7'd37:  r = ld_i(3, S_P3);
			7'd38:  r = rr_i(OP_MUL, 5, 2, 3);
			7'd39:  r = sh_i(OP_DIVP, 5, 5, 8);
			7'd40:  r = ld_i(3, S_P2);
			7'd41:  r = rr_i(OP_MUL, 6, 1, 3);
			7'd42:  r = sh_i(OP_SHL, 6, 6, 12);
			7'd43:  r = rr_i(OP_ADD, 5, 5, 6);
			7'd44:  r = ld_i(3, S_K2P47);
			7'd45:  r = rr_i(OP_ADD, 5, 3, 5);
			7'd46:  r = ld_i(3, S_P1);
			7'd47:  r = rr_i(OP_MUL, 5, 5, 3);
			7'd48:  r = sh_i(OP_DIVP, 5, 5, 33);
			7'd49:  r = ld_i(0, S_ADC_P);
			7'd50:  r = ld_i(3, S_K1M);
			7'd51:  r = rr_i(OP_SUB, 0, 3, 0);
			7'd52:  r = sh_i(OP_SHL, 0, 0, 31);
			7'd53:  r = rr_i(OP_SUB, 0, 0, 4);
			7'd54:  r = ld_i(3, S_K3125);
			7'd55:  r = rr_i(OP_MUL, 0, 0, 3);
			7'd56:  r = rr_i(OP_DIV, 0, 0, 5);
			7'd57:  r = sh_i(OP_DIVP, 6, 0, 13);
			7'd58:  r = ld_i(3, S_P9);
			7'd59:  r = rr_i(OP_MUL, 7, 3, 6);
			7'd60:  r = rr_i(OP_MUL, 7, 7, 6);
			7'd61:  r = sh_i(OP_DIVP, 7, 7, 25);
			7'd62:  r = ld_i(3, S_P8);
			7'd63:  r = rr_i(OP_MUL, 8, 3, 0);
			7'd64:  r = sh_i(OP_DIVP, 8, 8, 19);
			7'd65:  r = rr_i(OP_ADD, 0, 0, 7);
			7'd66:  r = rr_i(OP_ADD, 0, 0, 8);
			7'd67:  r = sh_i(OP_DIVP, 0, 0, 8);
			7'd68:  r = ld_i(3, S_P7);
			7'd69:  r = sh_i(OP_SHL, 3, 3, 4);
			7'd70:  r = rr_i(OP_ADD, 0, 0, 3);
			7'd71:  r = rr_i(OP_OUTP, 0, 0, 0);
			// humidity
			7'd72:  r = ld_i(0, S_K76800);
			7'd73:  r = rr_i(OP_SUB, 1, 15, 0);
			7'd74:  r = ld_i(0, S_ADC_H);
			7'd75:  r = sh_i(OP_SHL, 0, 0, 14);
			7'd76:  r = ld_i(2, S_H4);
			7'd77:  r = sh_i(OP_SHL, 2, 2, 20);
			7'd78:  r = rr_i(OP_SUB, 0, 0, 2);
			7'd79:  r = ld_i(2, S_H5);
			7'd80:  r = rr_i(OP_MUL, 2, 2, 1);
			7'd81:  r = rr_i(OP_SUB, 0, 0, 2);
			7'd82:  r = ld_i(2, S_K16384);
			7'd83:  r = rr_i(OP_ADD, 0, 0, 2);
			7'd84:  r = sh_i(OP_DIVP, 0, 0, 15);
			7'd85:  r = ld_i(2, S_H6);
			7'd86:  r = rr_i(OP_MUL, 2, 1, 2);
			7'd87:  r = sh_i(OP_DIVP, 2, 2, 10);
			7'd88:  r = ld_i(3, S_H3);
			7'd89:  r = rr_i(OP_MUL, 3, 1, 3);
			7'd90:  r = sh_i(OP_DIVP, 3, 3, 11);
			7'd91:  r = ld_i(4, S_K32768);
			7'd92:  r = rr_i(OP_ADD, 3, 3, 4);
			7'd93:  r = rr_i(OP_MUL, 2, 2, 3);
			7'd94:  r = sh_i(OP_DIVP, 2, 2, 10);
			7'd95:  r = ld_i(4, S_K2097152);
			7'd96:  r = rr_i(OP_ADD, 4, 2, 4);
			7'd97:  r = ld_i(2, S_H2);
			7'd98:  r = rr_i(OP_MUL, 4, 4, 2);
			7'd99:  r = ld_i(2, S_K8192);
			7'd100: r = rr_i(OP_ADD, 4, 4, 2);
			7'd101: r = sh_i(OP_DIVP, 2, 4, 14);
			7'd102: r = rr_i(OP_MUL, 3, 0, 2);
			7'd103: r = sh_i(OP_DIVP, 4, 3, 15);
			7'd104: r = rr_i(OP_MUL, 4, 4, 4);
			7'd105: r = sh_i(OP_DIVP, 4, 4, 7);
			7'd106: r = ld_i(2, S_H1);
			7'd107: r = rr_i(OP_MUL, 4, 4, 2);
			7'd108: r = sh_i(OP_DIVP, 4, 4, 4);
			7'd109: r = rr_i(OP_SUB, 4, 3, 4);
			7'd110: r = rr_i(OP_OUTH, 0, 4, 0);
			default: r = rr_i(OP_END, 0, 0, 0);
		endcase
		return r;
	endfunction

endpackage

// ===== hw/rtl/environmental_sensor_compensation.sv =====
`timescale 1ns / 1ps
// Top level of the sensor compensation block: configuration registers,
// sequencer and datapath. Depends on esc_pkg, esc_ctrl, esc_dp, esc_ram.
//
// channel   dir  handshake                      word
// s_axis    in   s_axis_tvalid / s_axis_tready  raw temperature, pressure, humidity
// m_axis    out  m_axis_tvalid / m_axis_tready  compensated readings, fault in tuser
// cfg       in   cfg_valid / cfg_ready          register index and write data
//
// Each word is taken in the idle state, then runs 112 program steps (111
// instructions and the end step), each a register RAM read, then execute;
// the 21 multiplies wait on the shared 32x32 multiplier and the one divide
// for pressure waits on the divider. A publish state ends the word.
// Reset clears sequencer, settings and fine temperature; all channels enabled.
// A finished word waits in the output register; the next input word is taken
// meanwhile, and a second result waits until the output register drains.
module environmental_sensor_compensation import esc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	// [19:0] raw_temperature, [39:20] raw_pressure, [55:40] raw_humidity
	input  logic [IN_W-1:0]   s_axis_tdata,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	// [15:0] temperature_centi, [47:16] pressure_q24_8, [64:48] humidity_q7_10,
	// [96:65] fine_temperature, [103:97] zero
	output logic [OUT_W-1:0]  m_axis_tdata,
	// [0] pressure_fault
	output logic              m_axis_tuser,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [63:0]       cfg_data
);

	cfg_t     cfg_q;
	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Configuration writes are always taken; unknown indexes are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.en  <= 3'd7;
			cfg_q.tc  <= '0;
			cfg_q.pa  <= '0;
			cfg_q.pb  <= '0;
			cfg_q.pc  <= '0;
			cfg_q.hc  <= '0;
			cfg_q.off <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_ENABLE: cfg_q.en  <= cfg_data[2:0];
				CFG_TEMP:   cfg_q.tc  <= cfg_data[47:0];
				CFG_PRES_A: cfg_q.pa  <= cfg_data[47:0];
				CFG_PRES_B: cfg_q.pb  <= cfg_data[47:0];
				CFG_PRES_C: cfg_q.pc  <= cfg_data[47:0];
				CFG_HUM:    cfg_q.hc  <= cfg_data;
				CFG_OFFSET: cfg_q.off <= cfg_data[20:0];
				default: ;
			endcase
		end
	end

	// sequencer: steps the program, owns input and output handshakes
	esc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// datapath: register RAM, ALU, multiplier, divider, result registers
	esc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_data   (s_axis_tdata),
		.cmd       (cmd),
		.stat      (stat),
		.out_data  (m_axis_tdata),
		.out_fault (m_axis_tuser)
	);

endmodule

// ===== hw/rtl/esc_ram.sv =====
`timescale 1ns / 1ps
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module esc_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

// ===== hw/rtl/esc_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer for the compensation block: walks the program and issues commands.
// Depends on esc_pkg.
module esc_ctrl import esc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output dp_cmd_t  cmd,
	input  dp_stat_t stat
);

	state_t           state_q, state_d;
	logic [PC_W-1:0]  pc_q;
	logic             out_valid_q;
	instr_t           ins;
	logic             is_unit;
	logic             advance;
	logic             publish;

	assign ins     = prog(pc_q);
	assign is_unit = (ins.op == OP_MUL) || (ins.op == OP_DIV);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:    if (in_valid) state_d = ST_FETCH;
			ST_FETCH:   state_d = ST_EXEC;
			ST_EXEC: begin
				if (ins.op == OP_END) state_d = ST_PUBLISH;
				else if (is_unit) state_d = ST_WAIT;
				else state_d = ST_FETCH;
			end
			ST_WAIT:    if (stat.unit_done) state_d = ST_FETCH;
			ST_PUBLISH: if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		advance     = 1'b0;
		publish     = 1'b0;
		cmd.capture = 1'b0;
		cmd.exec    = 1'b0;
		cmd.publish = 1'b0;
		cmd.ins     = ins;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_FETCH: ;
			ST_EXEC: begin
				cmd.exec = 1'b1;
				advance  = !is_unit && (ins.op != OP_END);
			end
			ST_WAIT:  advance = stat.unit_done;
			ST_PUBLISH: begin
				publish     = !out_valid_q || out_ready;
				cmd.publish = publish;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pc_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.capture) pc_q <= '0;
			else if (advance) pc_q <= pc_q + PC_W'(1);
			if (publish) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== hw/rtl/esc_dp.sv =====
`timescale 1ns / 1ps
// Datapath: register RAM, combinational ALU, shared multiplier and divider,
// result registers. Depends on esc_pkg and esc_ram.
module esc_dp import esc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic [IN_W-1:0]  in_data,
	input  dp_cmd_t          cmd,
	output dp_stat_t         stat,
	output logic [OUT_W-1:0] out_data,
	output logic             out_fault
);

	instr_t        ins;
	logic [19:0]   adc_t_q, adc_p_q;
	logic [15:0]   adc_h_q;
	logic [DW-1:0] ra_data, rb_data;
	logic [DW-1:0] lit;
	logic [DW-1:0] alu;
	logic          alu_we;
	logic          we;
	logic [DW-1:0] wdata;
	logic [DW-1:0] mask;
	logic [DW-1:0] fine_sel;

	// multiplier
	logic [DW-1:0] ma_q, mb_q, acc_q;
	logic [1:0]    mcnt_q;
	logic          mbusy_q, mdone_q;
	logic [31:0]   mx, my;
	logic [63:0]   prod, term;

	// divider
	logic [DW-1:0] dq_q, dd_q, rem_q;
	logic          dneg_q, dzero_q, dbusy_q, ddone_q;
	logic [5:0]    dcnt_q;
	logic [DW:0]   rem_sh, diff;
	logic [DW-1:0] div_res;

	// results
	logic [31:0]   fine_store_q, fine_w_q;
	logic [15:0]   temp_w_q;
	logic [31:0]   pres_w_q;
	logic [16:0]   hum_w_q;
	logic          fault_q, fault_w_q;
	logic [15:0]   temp_o_q;
	logic [31:0]   pres_o_q, fine_o_q;
	logic [16:0]   hum_o_q;
	logic          fault_o_q;

	assign ins = cmd.ins;

	esc_ram #(.WIDTH(DW), .DEPTH(REGS)) u_regs (
		.clk     (clk),
		.we      (we),
		.waddr   (ins.dst),
		.wdata   (wdata),
		.raddr_a (ins.ra),
		.raddr_b (ins.rb),
		.rdata_a (ra_data),
		.rdata_b (rb_data)
	);

	always_comb begin
		case (ins.src)
			S_ADC_T:    lit = {44'd0, adc_t_q};
			S_ADC_P:    lit = {44'd0, adc_p_q};
			S_ADC_H:    lit = {48'd0, adc_h_q};
			S_T1:       lit = {48'd0, cfg.tc[15:0]};
			S_T2:       lit = {{48{cfg.tc[31]}}, cfg.tc[31:16]};
			S_T3:       lit = {{48{cfg.tc[47]}}, cfg.tc[47:32]};
			S_P1:       lit = {48'd0, cfg.pa[15:0]};
			S_P2:       lit = {{48{cfg.pa[31]}}, cfg.pa[31:16]};
			S_P3:       lit = {{48{cfg.pa[47]}}, cfg.pa[47:32]};
			S_P4:       lit = {{48{cfg.pb[15]}}, cfg.pb[15:0]};
			S_P5:       lit = {{48{cfg.pb[31]}}, cfg.pb[31:16]};
			S_P6:       lit = {{48{cfg.pb[47]}}, cfg.pb[47:32]};
			S_P7:       lit = {{48{cfg.pc[15]}}, cfg.pc[15:0]};
			S_P8:       lit = {{48{cfg.pc[31]}}, cfg.pc[31:16]};
			S_P9:       lit = {{48{cfg.pc[47]}}, cfg.pc[47:32]};
			S_H1:       lit = {56'd0, cfg.hc[7:0]};
			S_H2:       lit = {{48{cfg.hc[23]}}, cfg.hc[23:8]};
			S_H3:       lit = {56'd0, cfg.hc[31:24]};
			S_H4:       lit = {{52{cfg.hc[43]}}, cfg.hc[43:32]};
			S_H5:       lit = {{52{cfg.hc[55]}}, cfg.hc[55:44]};
			S_H6:       lit = {{56{cfg.hc[63]}}, cfg.hc[63:56]};
			S_OFFSET:   lit = {{43{cfg.off[20]}}, cfg.off};
			S_K128:     lit = 64'd128;
			S_K128000:  lit = 64'd128000;
			S_K2P47:    lit = 64'd140737488355328;
			S_K1M:      lit = 64'd1048576;
			S_K3125:    lit = 64'd3125;
			S_K76800:   lit = 64'd76800;
			S_K16384:   lit = 64'd16384;
			S_K32768:   lit = 64'd32768;
			S_K2097152: lit = 64'd2097152;
			S_K8192:    lit = 64'd8192;
			default:    lit = '0;
		endcase
	end

	assign mask     = (64'd1 << ins.sh) - 64'd1;
	assign fine_sel = cfg.en[0] ? ra_data : {{32{fine_store_q[31]}}, fine_store_q};

	always_comb begin
		alu    = '0;
		alu_we = 1'b0;
		case (ins.op)
			OP_LD:   begin alu = lit; alu_we = 1'b1; end
			OP_ADD:  begin alu = ra_data + rb_data; alu_we = 1'b1; end
			OP_SUB:  begin alu = ra_data - rb_data; alu_we = 1'b1; end
			OP_DIVP: begin
				// truncate toward zero: bias negative values before the shift
				alu    = $signed(ra_data + (ra_data[63] ? mask : 64'd0)) >>> ins.sh;
				alu_we = 1'b1;
			end
			OP_SHL:  begin alu = ra_data << ins.sh; alu_we = 1'b1; end
			OP_FINE: begin alu = fine_sel; alu_we = 1'b1; end
			default: ;
		endcase
	end

	assign we    = (cmd.exec && alu_we) || mdone_q || ddone_q;
	assign wdata = mdone_q ? acc_q : (ddone_q ? div_res : alu);
	assign stat.unit_done = mdone_q || ddone_q;

	// 64x64 low product from three 32x32 partial products
	assign mx   = (mcnt_q == 2'd1) ? ma_q[63:32] : ma_q[31:0];
	assign my   = (mcnt_q == 2'd2) ? mb_q[63:32] : mb_q[31:0];
	assign prod = mx * my;
	assign term = (mcnt_q == 2'd0) ? prod : {prod[31:0], 32'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mbusy_q <= 1'b0;
			mdone_q <= 1'b0;
			mcnt_q  <= '0;
		end else begin
			mdone_q <= 1'b0;
			if (cmd.exec && ins.op == OP_MUL) begin
				mbusy_q <= 1'b1;
				mcnt_q  <= '0;
			end else if (mbusy_q) begin
				mcnt_q <= mcnt_q + 2'd1;
				if (mcnt_q == 2'd2) begin
					mbusy_q <= 1'b0;
					mdone_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && ins.op == OP_MUL) begin
			ma_q <= ra_data;
			mb_q <= rb_data;
		end else if (mbusy_q) begin
			acc_q <= ((mcnt_q == 2'd0) ? 64'd0 : acc_q) + term;
		end
	end

	// restoring divider on magnitudes, one quotient bit per cycle
	assign rem_sh  = {rem_q, dq_q[63]};
	assign diff    = rem_sh - {1'b0, dd_q};
	assign div_res = dzero_q ? 64'd0 : (dneg_q ? (64'd0 - dq_q) : dq_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dbusy_q <= 1'b0;
			ddone_q <= 1'b0;
			dcnt_q  <= '0;
			fault_q <= 1'b0;
		end else begin
			ddone_q <= 1'b0;
			if (cmd.exec && ins.op == OP_DIV) begin
				dbusy_q <= 1'b1;
				dcnt_q  <= '0;
				fault_q <= (rb_data == 64'd0);
			end else if (dbusy_q) begin
				dcnt_q <= dcnt_q + 6'd1;
				if (dcnt_q == 6'd63) begin
					dbusy_q <= 1'b0;
					ddone_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && ins.op == OP_DIV) begin
			dq_q    <= ra_data[63] ? (64'd0 - ra_data) : ra_data;
			dd_q    <= rb_data[63] ? (64'd0 - rb_data) : rb_data;
			rem_q   <= '0;
			dneg_q  <= ra_data[63] ^ rb_data[63];
			dzero_q <= (rb_data == 64'd0);
		end else if (dbusy_q) begin
			if (!diff[DW]) begin
				rem_q <= diff[DW-1:0];
				dq_q  <= {dq_q[62:0], 1'b1};
			end else begin
				rem_q <= rem_sh[DW-1:0];
				dq_q  <= {dq_q[62:0], 1'b0};
			end
		end
	end

	// stored fine temperature
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fine_store_q <= '0;
		end else if (cmd.exec && ins.op == OP_FINE && cfg.en[0]) begin
			fine_store_q <= ra_data[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			adc_t_q <= in_data[19:0];
			adc_p_q <= in_data[39:20];
			adc_h_q <= in_data[55:40];
		end
		if (cmd.exec) begin
			case (ins.op)
				OP_FINE: fine_w_q <= fine_sel[31:0];
				OP_OUTT: begin
					if (!cfg.en[0]) temp_w_q <= '0;
					else if ($signed(ra_data) > 64'sd32767) temp_w_q <= 16'h7fff;
					else if ($signed(ra_data) < -64'sd32768) temp_w_q <= 16'h8000;
					else temp_w_q <= ra_data[15:0];
				end
				OP_OUTP: begin
					fault_w_q <= cfg.en[1] && fault_q;
					if (!cfg.en[1] || fault_q || ra_data[63]) pres_w_q <= '0;
					else if (ra_data[62:32] != '0) pres_w_q <= 32'hffff_ffff;
					else pres_w_q <= ra_data[31:0];
				end
				OP_OUTH: begin
					if (!cfg.en[2] || ra_data[63]) hum_w_q <= '0;
					else if (ra_data > HUM_MAX) hum_w_q <= HUM_SAT;
					else hum_w_q <= ra_data[28:12];
				end
				default: ;
			endcase
		end
		if (cmd.publish) begin
			temp_o_q  <= temp_w_q;
			pres_o_q  <= pres_w_q;
			hum_o_q   <= hum_w_q;
			fault_o_q <= fault_w_q;
			fine_o_q  <= fine_w_q;
		end
	end

	assign out_data  = {7'd0, fine_o_q, hum_o_q, pres_o_q, temp_o_q};
	assign out_fault = fault_o_q;

endmodule
